// File: src/scdec_pkg.sv
// Shared constants, codes and character helpers for the serial command controller.
`default_nettype none

package scdec_pkg;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ERR  = 2'd2;

  localparam logic [3:0] REPLY_STOP    = 4'd0;
  localparam logic [3:0] REPLY_RUN     = 4'd1;
  localparam logic [3:0] REPLY_STATUS  = 4'd2;
  localparam logic [3:0] REPLY_PERCENT = 4'd3;
  localparam logic [3:0] REPLY_LONG    = 4'd4;
  localparam logic [3:0] REPLY_UART    = 4'd5;
  localparam logic [3:0] REPLY_BADPCT  = 4'd6;
  localparam logic [3:0] REPLY_UNKNOWN = 4'd7;
  localparam logic [3:0] REPLY_TIMEOUT = 4'd8;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RUN     = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [11:0] RUN_RESET     = 12'd1241;
  localparam logic [16:0] ELAPSED_MAX   = 17'h1FFFF;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [6:0] PCT_MAX = 7'd100;
  localparam logic [6:0] PCT_SAT = 7'd101;
  localparam logic [18:0] ROUND_HALF = 19'd50;
  // floor(x / 100) = (x * RECIP_100) >> 26 for x below 2^19
  localparam logic [19:0] RECIP_100 = 20'd671089;

  // Command words: STOP, 0, RUN, 1, S, STATUS; byte k of a word sits at bits 8k+7:8k
  localparam int NCAND = 6;
  localparam logic [NCAND-1:0][63:0] CAND_TXT = {
    64'h0000_5355_5441_5453,
    64'h0000_0000_0000_0053,
    64'h0000_0000_0000_0031,
    64'h0000_0000_004E_5552,
    64'h0000_0000_0000_0030,
    64'h0000_0000_504F_5453
  };
  localparam logic [NCAND-1:0][2:0] CAND_LEN = {3'd6, 3'd1, 3'd1, 3'd3, 3'd1, 3'd4};

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= 8'd97) && (c <= 8'd122)) ? (c - 8'd32) : c;
  endfunction

  function automatic logic [NCAND-1:0] cand_step(input logic [NCAND-1:0] c,
                                                 input logic [2:0] pos,
                                                 input logic [7:0] ch);
    logic [NCAND-1:0] nxt;
    for (int k = 0; k < NCAND; k++) begin
      nxt[k] = c[k] && (pos < CAND_LEN[k]) && (CAND_TXT[k][{pos, 3'b000} +: 8] == ch);
    end
    return nxt;
  endfunction

  function automatic logic [6:0] pct_acc(input logic [6:0] v, input logic [7:0] ch);
    logic [10:0] t;
    t = (11'(v) * 11'd10) + 11'(ch - CH_ZERO);
    return (t > 11'(PCT_SAT)) ? PCT_SAT : t[6:0];
  endfunction

endpackage

`default_nettype wire

// File: src/scdec_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module scdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/serial_command_dac_enable_controller.sv
// Serial command line controller driving a converter code and enable.
// Bytes, ticks, receiver errors: taken when idle and output free; reply in the next cycle.
// Line end: one line RAM read per cycle walks the stored line, then EVAL, for a
// percentage two registered multiplies (MUL1, MUL2), and EMIT once the output is free.
// Reset: line empty, code 0, idle count 0, timeout 3000, run code 1241;
// the line RAM is not cleared and needs no clearing pass.
`default_nettype none

module serial_command_dac_enable_controller
  import scdec_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [3:0]  reply_o,
  output logic      [11:0] level_code_o,
  output logic             enable_o,
  output logic      [6:0]  percent_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(LINE_CAPACITY);
  localparam logic [LW-1:0] LEN_LIMIT = LW'(LINE_CAPACITY - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_MUL1 = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [3:0] PH_LEAD   = 4'd0;
  localparam logic [3:0] PH_WORD   = 4'd1;
  localparam logic [3:0] PH_WTRAIL = 4'd2;
  localparam logic [3:0] PH_DEAD   = 4'd3;
  localparam logic [3:0] PH_PPRE   = 4'd4;
  localparam logic [3:0] PH_PSIGN  = 4'd5;
  localparam logic [3:0] PH_PDIG   = 4'd6;
  localparam logic [3:0] PH_PTRAIL = 4'd7;
  localparam logic [3:0] PH_PBAD   = 4'd8;

  logic [2:0]       state_q, state_d;
  logic [15:0]      timeout_q;
  logic [11:0]      run_q;
  logic [LW-1:0]    len_q, len_d;
  logic [11:0]      code_q, code_d;
  logic [16:0]      elapsed_q, elapsed_d;
  logic [LW-1:0]    ptr_q, ptr_d;
  logic             rv_q, rv_d;
  logic             zero_q, zero_d;
  logic [3:0]       phase_q, phase_d;
  logic [NCAND-1:0] cand_q, cand_d;
  logic [2:0]       wl_q, wl_d;
  logic [6:0]       val_q, val_d;
  logic             neg_q, neg_d;
  logic [3:0]       rep_q, rep_d;
  logic [18:0]      prod1_q, prod1_d;
  logic             out_valid_q, out_valid_d;
  logic [3:0]       out_reply_q, out_reply_d;
  logic [11:0]      out_dac_q, out_dac_d;
  logic [6:0]       out_pct_q, out_pct_d;

  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata;
  logic             in_fire, out_free;
  logic [16:0]      el_inc;
  logic [7:0]       ch;
  logic [NCAND-1:0] match;
  logic [38:0]      prod2;

  scdec_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(rx_byte_i),
    .re_i   (ram_re),
    .raddr_i(ptr_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign el_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : (elapsed_q + 17'd1);
  assign ch     = to_upper(ram_rdata);
  assign prod2  = 39'(prod1_q) * 39'(RECIP_100);

  always_comb begin
    for (int k = 0; k < NCAND; k++) begin
      match[k] = cand_q[k] && (wl_q == CAND_LEN[k]);
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    code_d      = code_q;
    elapsed_d   = elapsed_q;
    ptr_d       = ptr_q;
    rv_d        = rv_q;
    zero_d      = zero_q;
    phase_d     = phase_q;
    cand_d      = cand_q;
    wl_d        = wl_q;
    val_d       = val_q;
    neg_d       = neg_q;
    rep_d       = rep_q;
    prod1_d     = prod1_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_reply_d = out_reply_q;
    out_dac_d   = out_dac_q;
    out_pct_d   = out_pct_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (operation_i)
            OP_BYTE: begin
              if ((rx_byte_i == CH_CR) || (rx_byte_i == CH_LF)) begin
                if (len_q != '0) begin
                  ptr_d   = '0;
                  rv_d    = 1'b0;
                  zero_d  = 1'b0;
                  phase_d = PH_LEAD;
                  cand_d  = '1;
                  wl_d    = 3'd0;
                  val_d   = 7'd0;
                  neg_d   = 1'b0;
                  state_d = ST_WALK;
                end
              end else if (len_q < LEN_LIMIT) begin
                ram_we = 1'b1;
                len_d  = len_q + LW'(1);
              end else begin
                len_d       = '0;
                code_d      = 12'd0;
                elapsed_d   = 17'd0;
                out_valid_d = 1'b1;
                out_reply_d = REPLY_LONG;
                out_dac_d   = 12'd0;
                out_pct_d   = 7'd0;
              end
            end
            OP_TICK: begin
              if ((code_q != 12'd0) && (el_inc > {1'b0, timeout_q})) begin
                code_d      = 12'd0;
                elapsed_d   = 17'd0;
                out_valid_d = 1'b1;
                out_reply_d = REPLY_TIMEOUT;
                out_dac_d   = 12'd0;
                out_pct_d   = 7'd0;
              end else begin
                elapsed_d = el_inc;
              end
            end
            OP_ERR: begin
              len_d       = '0;
              code_d      = 12'd0;
              elapsed_d   = 17'd0;
              out_valid_d = 1'b1;
              out_reply_d = REPLY_UART;
              out_dac_d   = 12'd0;
              out_pct_d   = 7'd0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_WALK: begin
        rv_d = (ptr_q < len_q);
        if (ptr_q < len_q) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + LW'(1);
        end
        if (!rv_q && (ptr_q == len_q)) begin
          state_d = ST_EVAL;
        end
        if (rv_q && !zero_q) begin
          if (ch == CH_NUL) begin
            zero_d = 1'b1;
          end else begin
            case (phase_q)
              PH_LEAD: begin
                if (!is_blank(ch)) begin
                  if (ch == CH_P) begin
                    phase_d = PH_PPRE;
                  end else begin
                    phase_d = PH_WORD;
                    cand_d  = cand_step(cand_q, 3'd0, ch);
                    wl_d    = 3'd1;
                  end
                end
              end
              PH_WORD: begin
                if (is_blank(ch)) begin
                  phase_d = PH_WTRAIL;
                end else begin
                  cand_d = cand_step(cand_q, wl_q, ch);
                  wl_d   = (wl_q == 3'd7) ? wl_q : (wl_q + 3'd1);
                end
              end
              PH_WTRAIL: begin
                if (!is_blank(ch)) begin
                  phase_d = PH_DEAD;
                end
              end
              PH_PPRE: begin
                if ((ch == CH_PLUS) || (ch == CH_MINUS)) begin
                  neg_d   = (ch == CH_MINUS);
                  phase_d = PH_PSIGN;
                end else if (is_digit(ch)) begin
                  val_d   = pct_acc(val_q, ch);
                  phase_d = PH_PDIG;
                end else if (!is_blank(ch)) begin
                  phase_d = PH_PBAD;
                end
              end
              PH_PSIGN: begin
                if (is_digit(ch)) begin
                  val_d   = pct_acc(val_q, ch);
                  phase_d = PH_PDIG;
                end else begin
                  phase_d = PH_PBAD;
                end
              end
              PH_PDIG: begin
                if (is_digit(ch)) begin
                  val_d = pct_acc(val_q, ch);
                end else if (is_blank(ch)) begin
                  phase_d = PH_PTRAIL;
                end else begin
                  phase_d = PH_PBAD;
                end
              end
              PH_PTRAIL: begin
                if (!is_blank(ch)) begin
                  phase_d = PH_PBAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_EVAL: begin
        state_d = ST_EMIT;
        case (phase_q)
          PH_WORD, PH_WTRAIL: begin
            if (match[0] || match[1]) begin
              rep_d  = REPLY_STOP;
              code_d = 12'd0;
            end else if (match[2] || match[3]) begin
              rep_d  = REPLY_RUN;
              code_d = run_q;
            end else if (match[4] || match[5]) begin
              rep_d = REPLY_STATUS;
            end else begin
              rep_d  = REPLY_UNKNOWN;
              code_d = 12'd0;
            end
          end
          PH_PDIG, PH_PTRAIL: begin
            if ((val_q <= PCT_MAX) && !(neg_q && (val_q != 7'd0))) begin
              rep_d   = REPLY_PERCENT;
              state_d = ST_MUL1;
            end else begin
              rep_d  = REPLY_BADPCT;
              code_d = 12'd0;
            end
          end
          PH_PPRE, PH_PSIGN, PH_PBAD: begin
            rep_d  = REPLY_BADPCT;
            code_d = 12'd0;
          end
          default: begin
            rep_d  = REPLY_UNKNOWN;
            code_d = 12'd0;
          end
        endcase
      end

      ST_MUL1: begin
        prod1_d = (19'(run_q) * 19'(val_q)) + ROUND_HALF;
        state_d = ST_MUL2;
      end

      ST_MUL2: begin
        code_d  = prod2[37:26];
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_reply_d = rep_q;
          out_dac_d   = code_q;
          out_pct_d   = (rep_q == REPLY_PERCENT) ? val_q : 7'd0;
          len_d       = '0;
          elapsed_d   = 17'd0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIMEOUT_RESET;
      run_q       <= RUN_RESET;
      len_q       <= '0;
      code_q      <= 12'd0;
      elapsed_q   <= 17'd0;
      ptr_q       <= '0;
      rv_q        <= 1'b0;
      zero_q      <= 1'b0;
      phase_q     <= PH_LEAD;
      cand_q      <= '0;
      wl_q        <= 3'd0;
      val_q       <= 7'd0;
      neg_q       <= 1'b0;
      rep_q       <= REPLY_STOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      code_q      <= code_d;
      elapsed_q   <= elapsed_d;
      ptr_q       <= ptr_d;
      rv_q        <= rv_d;
      zero_q      <= zero_d;
      phase_q     <= phase_d;
      cand_q      <= cand_d;
      wl_q        <= wl_d;
      val_q       <= val_d;
      neg_q       <= neg_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_RUN:     run_q <= cfg_data_i[11:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q     <= prod1_d;
    out_reply_q <= out_reply_d;
    out_dac_q   <= out_dac_d;
    out_pct_q   <= out_pct_d;
  end

  assign out_valid_o  = out_valid_q;
  assign reply_o      = out_reply_q;
  assign level_code_o = out_dac_q;
  assign enable_o     = (out_dac_q != 12'd0);
  assign percent_o    = out_pct_q;

endmodule

`default_nettype wire
